// ----- rtl/kact_pkg.sv -----
package kact_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W = 9;
    localparam int TYPE_W = 21;
    localparam int KIND_W = 2;
    localparam int SEL_W = 10;
    localparam int CNT_W = 32;
    localparam int USED_W = 11;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] node_address;
        logic [TYPE_W-1:0] data_type;
        logic [KIND_W-1:0] access_kind;
        logic [SEL_W-1:0]  entry_select;
    } cmd_t;

    typedef struct packed {
        logic [SEL_W-1:0]  entry_index;
        logic              entry_valid;
        logic [ADDR_W-1:0] key_address;
        logic [TYPE_W-1:0] key_type;
        logic [CNT_W-1:0]  read_count;
        logic [CNT_W-1:0]  write_count;
        logic [CNT_W-1:0]  other_count;
        logic              table_full;
        logic [USED_W-1:0] used_entries;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] key_address;
        logic [TYPE_W-1:0] key_type;
        logic [CNT_W-1:0]  read_count;
        logic [CNT_W-1:0]  write_count;
        logic [CNT_W-1:0]  other_count;
    } entry_t;

endpackage

// ----- rtl/keyed_access_count_table.sv -----
// per-key access counter table held in a ring of entry cells that rotates one place per
// clock while an item sweeps; every item (count or read-back) takes one full turn of the
// ring, so no new start is taken until the last item has made its turn past the head
// logic, where the key compare and counter update happen. the result shows on rsp with
// done high for one cycle and must be captured then, since the receiver cannot stall;
// busy is already low in that cycle, so the next item may start there
module keyed_access_count_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  kact_pkg::cmd_t cmd,
    output logic           done,
    output kact_pkg::rsp_t rsp
);

    kact_pkg::entry_t chain [kact_pkg::TABLE_DEPTH];
    kact_pkg::entry_t wb;
    logic             shift;

    kact_head u_head (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .cur   (chain[0]),
        .shift (shift),
        .wb    (wb),
        .done  (done),
        .rsp   (rsp)
    );

    for (genvar k = 0; k < kact_pkg::TABLE_DEPTH; k++)
    begin : g_ring
        if (k == kact_pkg::TABLE_DEPTH - 1)
        begin : g_tail
            kact_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .din   (wb),
                .dout  (chain[k])
            );
        end
        else
        begin : g_body
            kact_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .din   (chain[k+1]),
                .dout  (chain[k])
            );
        end
    end

endmodule

// ----- rtl/kact_cell.sv -----
module kact_cell (
    input  logic            clk,
    input  logic            shift,
    input  kact_pkg::entry_t din,
    output kact_pkg::entry_t dout
);

    kact_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

// ----- rtl/kact_head.sv -----
module kact_head (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kact_pkg::cmd_t   cmd,
    input  kact_pkg::entry_t cur,
    output logic             shift,
    output kact_pkg::entry_t wb,
    output logic             done,
    output kact_pkg::rsp_t   rsp
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t                         state_reg;
    logic [kact_pkg::IDX_W-1:0]     step_reg;
    logic [kact_pkg::FILL_W-1:0]    fill_reg;
    logic [kact_pkg::FILL_W-1:0]    fill_next;
    logic                           found_reg;
    logic                           done_reg;
    kact_pkg::cmd_t                 item_reg;
    kact_pkg::rsp_t                 res_reg;
    kact_pkg::rsp_t                 res_next;
    kact_pkg::rsp_t                 res_start;
    kact_pkg::entry_t               cap_entry;
    kact_pkg::entry_t               fresh;
    logic                           cap;
    logic                           in_fill;
    logic                           at_fill;
    logic                           last;

    function automatic kact_pkg::entry_t bump(input kact_pkg::entry_t e,
                                              input logic [kact_pkg::KIND_W-1:0] kind);
        kact_pkg::entry_t r;
        r = e;
        case (kind)
            kact_pkg::KIND_READ:
            begin
                if (e.read_count != '1)
                begin
                    r.read_count = e.read_count + 1'b1;
                end
            end
            kact_pkg::KIND_WRITE:
            begin
                if (e.write_count != '1)
                begin
                    r.write_count = e.write_count + 1'b1;
                end
            end
            default:
            begin
                if (e.other_count != '1)
                begin
                    r.other_count = e.other_count + 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    assign in_fill = kact_pkg::FILL_W'(step_reg) < fill_reg;
    assign at_fill = kact_pkg::FILL_W'(step_reg) == fill_reg;
    assign last    = step_reg == kact_pkg::IDX_W'(kact_pkg::TABLE_DEPTH - 1);

    always_comb
    begin
        fresh              = '0;
        fresh.key_address  = item_reg.node_address;
        fresh.key_type     = item_reg.data_type;
        wb        = cur;
        cap       = 1'b0;
        cap_entry = cur;
        fill_next = fill_reg;
        if (item_reg.action == kact_pkg::ACT_COUNT)
        begin
            if (!found_reg && in_fill && cur.key_address == item_reg.node_address
                && cur.key_type == item_reg.data_type)
            begin
                cap_entry = bump(cur, item_reg.access_kind);
                wb        = cap_entry;
                cap       = 1'b1;
            end
            else if (!found_reg && at_fill)
            begin
                // first free slot reached with no hit: append the key here
                cap_entry = bump(fresh, item_reg.access_kind);
                wb        = cap_entry;
                cap       = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
        end
        else
        begin
            if (in_fill && 32'(step_reg) == 32'(item_reg.entry_select))
            begin
                cap = 1'b1;
            end
        end

        res_next = res_reg;
        if (cap)
        begin
            res_next.entry_index = kact_pkg::SEL_W'(step_reg);
            res_next.entry_valid = 1'b1;
            res_next.key_address = cap_entry.key_address;
            res_next.key_type    = cap_entry.key_type;
            res_next.read_count  = cap_entry.read_count;
            res_next.write_count = cap_entry.write_count;
            res_next.other_count = cap_entry.other_count;
            res_next.table_full  = 1'b0;
        end
        res_next.used_entries = kact_pkg::USED_W'(fill_next);
    end

    always_comb
    begin
        res_start = '0;
        if (cmd.action == kact_pkg::ACT_READ)
        begin
            res_start.entry_index = cmd.entry_select;
        end
        else
        begin
            // stays set only if the sweep finds neither the key nor a free slot
            res_start.table_full = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            fill_reg  <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    step_reg  <= step_reg + 1'b1;
                    fill_reg  <= fill_next;
                    found_reg <= found_reg | cap;
                    if (last)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            item_reg <= cmd;
            res_reg  <= res_start;
        end
        else if (state_reg == ST_SWEEP)
        begin
            res_reg <= res_next;
        end
    end

    assign busy  = state_reg != ST_IDLE;
    assign shift = state_reg == ST_SWEEP;
    assign done  = done_reg;
    assign rsp   = res_reg;

endmodule

// ----- tb/sv/keyed_access_count_table_tb.sv -----
`timescale 1ns / 1ps

module keyed_access_count_table_tb;

    typedef logic [kact_pkg::ADDR_W-1:0] addr_t;
    typedef logic [kact_pkg::TYPE_W-1:0] dtype_t;
    typedef logic [kact_pkg::KIND_W-1:0] kind_t;
    typedef logic [kact_pkg::SEL_W-1:0]  sel_t;

    localparam kind_t KIND_OTHER = 2'd2;
    localparam kind_t KIND_ODD   = 2'd3;

    // each item takes a full turn of the ring past the head
    localparam int ITEM_CYCLES  = kact_pkg::TABLE_DEPTH + 1;
    localparam int DRAIN_CYCLES = ITEM_CYCLES + 75;
    localparam int MAX_GAP      = ITEM_CYCLES + 35;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    kact_pkg::cmd_t cmd;
    logic done;
    kact_pkg::rsp_t rsp;

    kact_pkg::entry_t table_mirror [kact_pkg::TABLE_DEPTH];
    int filled;
    kact_pkg::rsp_t entry_reports_due [$];
    int mismatches;
    int burst_left;

    keyed_access_count_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    function automatic int key_slot(addr_t addr, dtype_t dtype);
        for (int i = 0; i < filled; i++)
        begin
            if (table_mirror[i].key_address == addr && table_mirror[i].key_type == dtype)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic kact_pkg::rsp_t entry_report(int slot);
        kact_pkg::rsp_t r;
        r = '0;
        r.entry_index = sel_t'(slot);
        r.entry_valid = 1'b1;
        r.key_address = table_mirror[slot].key_address;
        r.key_type    = table_mirror[slot].key_type;
        r.read_count  = table_mirror[slot].read_count;
        r.write_count = table_mirror[slot].write_count;
        r.other_count = table_mirror[slot].other_count;
        return r;
    endfunction

    // updates the mirror for one item and returns the entry it should report
    function automatic kact_pkg::rsp_t tally_item(kact_pkg::cmd_t c);
        kact_pkg::rsp_t r;
        int slot;
        r = '0;
        if (c.action == kact_pkg::ACT_READ)
        begin
            if (int'(c.entry_select) < filled)
            begin
                r = entry_report(int'(c.entry_select));
            end
            else
            begin
                r.entry_index = c.entry_select;
            end
        end
        else
        begin
            slot = key_slot(c.node_address, c.data_type);
            if (slot < 0 && filled >= kact_pkg::TABLE_DEPTH)
            begin
                r.table_full = 1'b1;
            end
            else
            begin
                if (slot < 0)
                begin
                    slot = filled;
                    table_mirror[slot] = '0;
                    table_mirror[slot].key_address = c.node_address;
                    table_mirror[slot].key_type = c.data_type;
                    filled++;
                end
                // kinds above write all land on the other counter
                case (c.access_kind)
                    kact_pkg::KIND_READ:
                    begin
                        if (table_mirror[slot].read_count != '1)
                        begin
                            table_mirror[slot].read_count++;
                        end
                    end
                    kact_pkg::KIND_WRITE:
                    begin
                        if (table_mirror[slot].write_count != '1)
                        begin
                            table_mirror[slot].write_count++;
                        end
                    end
                    default:
                    begin
                        if (table_mirror[slot].other_count != '1)
                        begin
                            table_mirror[slot].other_count++;
                        end
                    end
                endcase
                r = entry_report(slot);
            end
        end
        r.used_entries = filled[kact_pkg::USED_W-1:0];
        return r;
    endfunction

    function automatic kact_pkg::cmd_t count_cmd(addr_t addr, dtype_t dtype, kind_t kind);
        kact_pkg::cmd_t c;
        c.action = kact_pkg::ACT_COUNT;
        c.node_address = addr;
        c.data_type = dtype;
        c.access_kind = kind;
        c.entry_select = sel_t'($urandom_range(0, (1 << kact_pkg::SEL_W) - 1));
        return c;
    endfunction

    function automatic kact_pkg::cmd_t read_cmd(sel_t sel);
        kact_pkg::cmd_t c;
        c.action = kact_pkg::ACT_READ;
        c.node_address = addr_t'($urandom_range(0, (1 << kact_pkg::ADDR_W) - 1));
        c.data_type = dtype_t'($urandom_range(0, (1 << kact_pkg::TYPE_W) - 1));
        c.access_kind = kind_t'($urandom_range(0, 3));
        c.entry_select = sel;
        return c;
    endfunction

    function automatic kact_pkg::cmd_t random_key_cmd();
        return count_cmd(addr_t'($urandom_range(0, (1 << kact_pkg::ADDR_W) - 1)),
                         dtype_t'($urandom_range(0, (1 << kact_pkg::TYPE_W) - 1)),
                         kind_t'($urandom_range(0, 3)));
    endfunction

    // reads, hits on known keys, near misses and fresh keys
    function automatic kact_pkg::cmd_t random_cmd();
        kact_pkg::cmd_t c;
        int pick;
        int slot;
        int bit_pos;
        c = random_key_cmd();
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            c.action = kact_pkg::ACT_READ;
            if (filled > 0 && pick < 14)
            begin
                c.entry_select = sel_t'($urandom_range(0, filled - 1));
            end
        end
        else if (filled > 0 && pick < 65)
        begin
            slot = $urandom_range(0, filled - 1);
            c.node_address = table_mirror[slot].key_address;
            c.data_type = table_mirror[slot].key_type;
            if (pick >= 55)
            begin
                // one bit off an existing key
                bit_pos = $urandom_range(0, kact_pkg::ADDR_W + kact_pkg::TYPE_W - 1);
                if (bit_pos < kact_pkg::ADDR_W)
                begin
                    c.node_address[bit_pos] = ~c.node_address[bit_pos];
                end
                else
                begin
                    c.data_type[bit_pos - kact_pkg::ADDR_W] =
                        ~c.data_type[bit_pos - kact_pkg::ADDR_W];
                end
            end
        end
        return c;
    endfunction

    // start stays high after acceptance so back-to-back items need no toggle of it in between
    task automatic send_cmd(kact_pkg::cmd_t c);
        cmd <= c;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        entry_reports_due.push_back(tally_item(c));
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic issue(kact_pkg::cmd_t c);
        pace_sender();
        send_cmd(c);
    endtask

    task automatic test_reads_when_empty();
        issue(read_cmd('0));
        issue(read_cmd('1));
        issue(read_cmd(10'h155));
    endtask

    task automatic test_key_extremes();
        issue(count_cmd('0, '0, kact_pkg::KIND_READ));
        issue(count_cmd('1, '1, kact_pkg::KIND_WRITE));
        issue(count_cmd('0, '0, kact_pkg::KIND_WRITE));
        issue(count_cmd('0, '0, KIND_OTHER));
        issue(count_cmd('0, '0, KIND_ODD));
        issue(count_cmd('0, '1, kact_pkg::KIND_READ));
        issue(count_cmd('1, '0, KIND_ODD));
        issue(count_cmd('1, '1, kact_pkg::KIND_READ));
    endtask

    task automatic test_readback_edges();
        for (int i = 0; i <= filled; i++)
        begin
            issue(read_cmd(sel_t'(i)));
        end
        issue(read_cmd('1));
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++)
        begin
            issue(random_cmd());
        end
    endtask

    task automatic test_fill_table();
        kact_pkg::cmd_t c;
        while (filled < kact_pkg::TABLE_DEPTH)
        begin
            do
            begin
                c = random_key_cmd();
            end
            while (key_slot(c.node_address, c.data_type) >= 0);
            issue(c);
        end
    endtask

    task automatic test_full_table();
        kact_pkg::cmd_t c;
        for (int i = 0; i < 3; i++)
        begin
            do
            begin
                c = random_key_cmd();
                c.access_kind = kind_t'(i);
            end
            while (key_slot(c.node_address, c.data_type) >= 0);
            issue(c);
        end
        issue(count_cmd(table_mirror[kact_pkg::TABLE_DEPTH-1].key_address,
                        table_mirror[kact_pkg::TABLE_DEPTH-1].key_type,
                        kact_pkg::KIND_WRITE));
        issue(count_cmd(table_mirror[0].key_address, table_mirror[0].key_type, KIND_ODD));
        issue(read_cmd(sel_t'(kact_pkg::TABLE_DEPTH - 1)));
        issue(read_cmd('0));
    endtask

    always @(posedge clk)
    begin
        kact_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (entry_reports_due.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing outstanding, index %0d",
                                          rsp.entry_index));
            end
            else
            begin
                want = entry_reports_due.pop_front();
                compare_field("entry_index", 64'(rsp.entry_index), 64'(want.entry_index));
                compare_field("entry_valid", 64'(rsp.entry_valid), 64'(want.entry_valid));
                compare_field("key_address", 64'(rsp.key_address), 64'(want.key_address));
                compare_field("key_type", 64'(rsp.key_type), 64'(want.key_type));
                compare_field("read_count", 64'(rsp.read_count), 64'(want.read_count));
                compare_field("write_count", 64'(rsp.write_count), 64'(want.write_count));
                compare_field("other_count", 64'(rsp.other_count), 64'(want.other_count));
                compare_field("table_full", 64'(rsp.table_full), 64'(want.table_full));
                compare_field("used_entries", 64'(rsp.used_entries),
                              64'(want.used_entries));
            end
        end
    end

    initial
    begin
        int waited;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        filled = 0;
        mismatches = 0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reads_when_empty();
        test_key_extremes();
        test_readback_edges();
        test_random_traffic(300);
        test_fill_table();
        test_full_table();
        test_random_traffic(280);

        start <= 1'b0;
        waited = 0;
        while (entry_reports_due.size() != 0 && waited < 4 * DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (entry_reports_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d item results never arrived",
                                      entry_reports_due.size()));
        end

        if (mismatches == 0)
        begin
            $display("keyed_access_count_table_tb passed");
        end
        else
        begin
            $display("keyed_access_count_table_tb failed");
        end
        $finish;
    end

    // at most about 1620 items, each with its sweep and the longest pacing gap, fit nearly three times over
    initial
    begin
        #100ms;
        $display("keyed_access_count_table_tb failed");
        $finish;
    end

endmodule
